>>> rtl/core/bgsd_pkg.sv
package bgsd_pkg;

  localparam int ANGLE_W    = 16;
  localparam int SPAN_W     = 15;
  localparam int CNT_W      = 7;
  localparam int SEG_W      = 6;
  localparam int IDX_W      = 7;
  localparam int PROD_W     = 25;
  localparam int NUM_W      = 24;
  localparam int DIV_STAGES = IDX_W;

  localparam int MAX_SEGMENTS_DEF = 64;

  localparam logic signed [ANGLE_W-1:0] ZERO_ANGLE_RST    = '0;
  localparam logic signed [ANGLE_W-1:0] START_ANGLE_RST   = '0;
  localparam logic [SPAN_W-1:0]         SWEEP_SPAN_RST    = 15'd17280;
  localparam logic [CNT_W-1:0]          SEGMENT_COUNT_RST = 7'd32;

  typedef enum logic [1:0] {
    REG_ZERO_ANGLE,
    REG_START_ANGLE,
    REG_SWEEP_SPAN,
    REG_SEGMENT_COUNT
  } reg_addr_t;

  // segment index: sign of the floor quotient and its magnitude, saturated
  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] q;
  } idx_t;

  typedef struct packed {
    logic neg_z;
    logic neg_o;
    logic neg_n;
    logic small_o;
    logic small_n;
    logic swap_o;
    logic swap_n;
  } side_t;

  typedef struct packed {
    idx_t idx;
    logic short_arc;
    logic swap;
  } ang_t;

endpackage

>>> rtl/core/bgsd_divider.sv
module bgsd_divider (
  input  logic                         clk,
  input  logic [bgsd_pkg::NUM_W-1:0]   dividend,
  input  logic [bgsd_pkg::SPAN_W-1:0]  divisor,
  output logic [bgsd_pkg::IDX_W-1:0]   quotient
);

  localparam int NW = bgsd_pkg::NUM_W;
  localparam int QW = bgsd_pkg::IDX_W;
  localparam int NS = bgsd_pkg::DIV_STAGES;

  logic [NW-1:0] rem [NS];
  logic [QW-1:0] qt  [NS];
  logic          sat [NS];

  logic [NW:0] div_ext;
  assign div_ext = {(NW + 1 - bgsd_pkg::SPAN_W)'(0), divisor};

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [QW-1:0] q_in;
    logic          sat_in;
    logic [NW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign q_in   = '0;
      // quotient beyond the index range saturates
      assign sat_in = {1'b0, dividend} >= (div_ext << QW);
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign q_in   = qt[k-1];
      assign sat_in = sat[k-1];
    end

    assign trial = div_ext << (QW - 1 - k);
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      rem[k] <= ge ? NW'({1'b0, rem_in} - trial) : rem_in;
      qt[k]  <= q_in | (QW'(ge) << (QW - 1 - k));
      sat[k] <= sat_in;
    end
  end

  assign quotient = sat[NS-1] ? '1 : qt[NS-1];

endmodule

>>> rtl/core/bgsd_range.sv
module bgsd_range (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        gauge_empty,
  input  logic [bgsd_pkg::CNT_W-1:0]  n_eff,
  input  bgsd_pkg::idx_t              idx_z,
  input  bgsd_pkg::ang_t              ang_o,
  input  bgsd_pkg::ang_t              ang_n,
  output logic                        done,
  output logic [1:0]                  range_count,
  output logic [bgsd_pkg::SEG_W-1:0]  first_a,
  output logic [bgsd_pkg::SEG_W-1:0]  last_a,
  output logic [bgsd_pkg::SEG_W-1:0]  first_b,
  output logic [bgsd_pkg::SEG_W-1:0]  last_b
);

  localparam int QW = bgsd_pkg::IDX_W;

  typedef struct packed {
    logic          valid;
    logic [QW-1:0] first;
    logic [QW-1:0] last;
  } paint_t;

  function automatic paint_t paint(bgsd_pkg::ang_t a, bgsd_pkg::idx_t zi,
                                   logic [QW-1:0] zc, logic [QW-1:0] n_m1);
    bgsd_pkg::idx_t lo;
    bgsd_pkg::idx_t hi;
    logic [QW-1:0]  f;
    logic [QW-1:0]  l;
    paint_t         r;
    lo = a.swap ? a.idx : zi;
    hi = a.swap ? zi : a.idx;
    f = lo.neg ? '0 : lo.q;
    l = (hi.q > n_m1) ? n_m1 : hi.q;
    r.valid = !a.short_arc && !hi.neg && (l >= f);
    // the zero marker segment is never painted
    if (zc == f || zc == l) begin
      if (f == l) r.valid = 1'b0;
      else if (zc == f) f = f + 1'b1;
      else l = l - 1'b1;
    end
    r.first = f;
    r.last  = l;
    return r;
  endfunction

  logic [QW-1:0] n_m1;
  logic [QW-1:0] zc;
  paint_t        p_old_next, p_new_next;
  paint_t        p_old, p_new;
  logic          p_valid, p_empty;

  assign n_m1 = QW'(n_eff) - 1'b1;
  assign zc   = idx_z.neg ? '0 : ((idx_z.q > n_m1) ? n_m1 : idx_z.q);

  assign p_old_next = paint(ang_o, idx_z, zc, n_m1);
  assign p_new_next = paint(ang_n, idx_z, zc, n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
    end
    p_old   <= p_old_next;
    p_new   <= p_new_next;
    p_empty <= gauge_empty;
  end

  // symmetric difference of two intervals: at most two runs
  logic [1:0]    cnt_next;
  logic [QW-1:0] fa, la, fb, lb;
  logic          overlap, lp, rp;
  paint_t        lower, upper;

  always_comb begin
    cnt_next = 2'd0;
    fa = '0;
    la = '0;
    fb = '0;
    lb = '0;
    overlap = (p_old.last >= p_new.first) && (p_new.last >= p_old.first);
    lp = p_old.first != p_new.first;
    rp = p_old.last != p_new.last;
    lower = (p_old.first < p_new.first) ? p_old : p_new;
    upper = (p_old.first < p_new.first) ? p_new : p_old;
    if (p_empty) begin
      cnt_next = 2'd0;
    end else if (p_old.valid && p_new.valid) begin
      if (overlap) begin
        if (lp) begin
          cnt_next = 2'd1;
          fa = lower.first;
          la = upper.first - 1'b1;
        end
        if (rp) begin
          if (lp) begin
            cnt_next = 2'd2;
            fb = ((p_old.last < p_new.last) ? p_old.last : p_new.last) + 1'b1;
            lb = (p_old.last < p_new.last) ? p_new.last : p_old.last;
          end else begin
            cnt_next = 2'd1;
            fa = ((p_old.last < p_new.last) ? p_old.last : p_new.last) + 1'b1;
            la = (p_old.last < p_new.last) ? p_new.last : p_old.last;
          end
        end
      end else if (lower.last + 1'b1 == upper.first) begin
        cnt_next = 2'd1;
        fa = lower.first;
        la = upper.last;
      end else begin
        cnt_next = 2'd2;
        fa = lower.first;
        la = lower.last;
        fb = upper.first;
        lb = upper.last;
      end
    end else if (p_old.valid) begin
      cnt_next = 2'd1;
      fa = p_old.first;
      la = p_old.last;
    end else if (p_new.valid) begin
      cnt_next = 2'd1;
      fa = p_new.first;
      la = p_new.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_valid;
    end
    range_count <= cnt_next;
    first_a     <= fa[bgsd_pkg::SEG_W-1:0];
    last_a      <= la[bgsd_pkg::SEG_W-1:0];
    first_b     <= fb[bgsd_pkg::SEG_W-1:0];
    last_b      <= lb[bgsd_pkg::SEG_W-1:0];
  end

endmodule

>>> rtl/core/bar_gauge_segment_diff.sv
// a transfer passes the product, magnitude, divider and range registers before done rises
// throughput: one angle pair per cycle, busy stays low
// the depth is set by the seven-stage restoring divider, one quotient bit per stage
// the receiver cannot stall, so results leave in the cycle they are ready
// synchronous reset clears the pipeline valid bits and loads the register defaults
module bar_gauge_segment_diff #(
  parameter int MAX_SEGMENTS = bgsd_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [bgsd_pkg::ANGLE_W-1:0] old_angle,
  input  logic signed [bgsd_pkg::ANGLE_W-1:0] new_angle,
  output logic                               done,
  output logic [1:0]                         range_count,
  output logic [bgsd_pkg::SEG_W-1:0]         first_a,
  output logic [bgsd_pkg::SEG_W-1:0]         last_a,
  output logic [bgsd_pkg::SEG_W-1:0]         first_b,
  output logic [bgsd_pkg::SEG_W-1:0]         last_b,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int AW = bgsd_pkg::ANGLE_W;
  localparam int PW = bgsd_pkg::PROD_W;
  localparam int NW = bgsd_pkg::NUM_W;
  localparam int NS = bgsd_pkg::DIV_STAGES;
  localparam int CW = bgsd_pkg::CNT_W;

  // configuration registers
  logic signed [AW-1:0]             zero_angle;
  logic signed [AW-1:0]             start_angle;
  logic [bgsd_pkg::SPAN_W-1:0]      sweep_span;
  logic [CW-1:0]                    segment_count;
  logic                             wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_angle    <= bgsd_pkg::ZERO_ANGLE_RST;
      start_angle   <= bgsd_pkg::START_ANGLE_RST;
      sweep_span    <= bgsd_pkg::SWEEP_SPAN_RST;
      segment_count <= bgsd_pkg::SEGMENT_COUNT_RST;
    end else if (wr_en) begin
      unique case (bgsd_pkg::reg_addr_t'(paddr[3:2]))
        bgsd_pkg::REG_ZERO_ANGLE:    zero_angle    <= pwdata[AW-1:0];
        bgsd_pkg::REG_START_ANGLE:   start_angle   <= pwdata[AW-1:0];
        bgsd_pkg::REG_SWEEP_SPAN:    sweep_span    <= pwdata[bgsd_pkg::SPAN_W-1:0];
        bgsd_pkg::REG_SEGMENT_COUNT: segment_count <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bgsd_pkg::reg_addr_t'(paddr[3:2]))
      bgsd_pkg::REG_ZERO_ANGLE:    prdata = 32'(zero_angle);
      bgsd_pkg::REG_START_ANGLE:   prdata = 32'(start_angle);
      bgsd_pkg::REG_SWEEP_SPAN:    prdata = 32'(sweep_span);
      bgsd_pkg::REG_SEGMENT_COUNT: prdata = 32'(segment_count);
      default:                     prdata = '0;
    endcase
  end

  logic [CW-1:0] n_eff;
  logic          gauge_empty;

  assign n_eff = (int'(segment_count) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS) : segment_count;
  assign gauge_empty = (n_eff == '0) || (sweep_span == '0);

  // stage 1: offsets from segment zero times n, and lit arc length times n
  logic signed [AW:0]   d_o, d_n, a_o, a_n;
  logic [AW:0]          abs_o, abs_n;
  logic signed [PW-1:0] prod_z, prod_o, prod_n;
  logic [NW-1:0]        w_o, w_n;
  logic                 swap_o1, swap_n1, v1;

  assign d_o   = (AW+1)'(old_angle) - (AW+1)'(start_angle);
  assign d_n   = (AW+1)'(new_angle) - (AW+1)'(start_angle);
  assign a_o   = (AW+1)'(old_angle) - (AW+1)'(zero_angle);
  assign a_n   = (AW+1)'(new_angle) - (AW+1)'(zero_angle);
  assign abs_o = a_o[AW] ? (AW+1)'(-a_o) : a_o;
  assign abs_n = a_n[AW] ? (AW+1)'(-a_n) : a_n;

  logic signed [AW:0] d_z_full;
  assign d_z_full = (AW+1)'(zero_angle) - (AW+1)'(start_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    prod_z  <= PW'(d_z_full) * PW'($signed({1'b0, n_eff}));
    prod_o  <= PW'(d_o) * PW'($signed({1'b0, n_eff}));
    prod_n  <= PW'(d_n) * PW'($signed({1'b0, n_eff}));
    w_o     <= NW'(abs_o) * NW'(n_eff);
    w_n     <= NW'(abs_n) * NW'(n_eff);
    swap_o1 <= zero_angle > old_angle;
    swap_n1 <= zero_angle > new_angle;
  end

  // stage 2: magnitudes for the divider, half-step test
  logic [NW-1:0] mag_z, mag_o, mag_n;
  bgsd_pkg::side_t side2;
  logic v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    mag_z <= prod_z[PW-1] ? NW'(-prod_z) : NW'(prod_z);
    mag_o <= prod_o[PW-1] ? NW'(-prod_o) : NW'(prod_o);
    mag_n <= prod_n[PW-1] ? NW'(-prod_n) : NW'(prod_n);
    side2.neg_z   <= prod_z[PW-1];
    side2.neg_o   <= prod_o[PW-1];
    side2.neg_n   <= prod_n[PW-1];
    side2.small_o <= {w_o, 1'b0} < (NW+1)'(sweep_span);
    side2.small_n <= {w_n, 1'b0} < (NW+1)'(sweep_span);
    side2.swap_o  <= swap_o1;
    side2.swap_n  <= swap_n1;
  end

  // divider stages, flags travel alongside
  logic [bgsd_pkg::IDX_W-1:0] q_z, q_o, q_n;
  bgsd_pkg::side_t            side_pipe [NS];
  logic [NS-1:0]              v_pipe;

  bgsd_divider u_div_z (.clk(clk), .dividend(mag_z), .divisor(sweep_span), .quotient(q_z));
  bgsd_divider u_div_o (.clk(clk), .dividend(mag_o), .divisor(sweep_span), .quotient(q_o));
  bgsd_divider u_div_n (.clk(clk), .dividend(mag_n), .divisor(sweep_span), .quotient(q_n));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe <= '0;
    end else begin
      v_pipe <= {v_pipe[NS-2:0], v2};
    end
    side_pipe[0] <= side2;
    for (int i = 1; i < NS; i++) begin
      side_pipe[i] <= side_pipe[i-1];
    end
  end

  bgsd_pkg::idx_t idx_z;
  bgsd_pkg::ang_t ang_o, ang_n;
  bgsd_pkg::side_t sd;

  assign sd          = side_pipe[NS-1];
  assign idx_z.neg   = sd.neg_z;
  assign idx_z.q     = q_z;
  assign ang_o.idx.neg   = sd.neg_o;
  assign ang_o.idx.q     = q_o;
  assign ang_o.short_arc = sd.small_o;
  assign ang_o.swap      = sd.swap_o;
  assign ang_n.idx.neg   = sd.neg_n;
  assign ang_n.idx.q     = q_n;
  assign ang_n.short_arc = sd.small_n;
  assign ang_n.swap      = sd.swap_n;

  bgsd_range u_range (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v_pipe[NS-1]),
    .gauge_empty (gauge_empty),
    .n_eff       (n_eff),
    .idx_z       (idx_z),
    .ang_o       (ang_o),
    .ang_n       (ang_n),
    .done        (done),
    .range_count (range_count),
    .first_a     (first_a),
    .last_a      (last_a),
    .first_b     (first_b),
    .last_b      (last_b)
  );

`ifndef SYNTHESIS
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (done && range_count == 2'd0) |-> (first_a == '0 && last_a == '0))
    else $error("range a not cleared with no ranges");

  a_unused_b: assert property (@(posedge clk) disable iff (rst)
    (done && range_count != 2'd2) |-> (first_b == '0 && last_b == '0))
    else $error("range b not cleared with fewer than two ranges");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> range_count != 2'd3)
    else $error("range count out of range");
`endif

endmodule

>>> tb/bgsd_checker.sv
`timescale 1ns / 100ps

module bgsd_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [bgsd_pkg::ANGLE_W-1:0] old_angle,
  input  logic signed [bgsd_pkg::ANGLE_W-1:0] new_angle,
  input  logic                               done,
  input  logic [1:0]                         range_count,
  input  logic [bgsd_pkg::SEG_W-1:0]         first_a,
  input  logic [bgsd_pkg::SEG_W-1:0]         last_a,
  input  logic [bgsd_pkg::SEG_W-1:0]         first_b,
  input  logic [bgsd_pkg::SEG_W-1:0]         last_b,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output int                                 errors,
  output int                                 pending
);

  typedef struct packed {
    logic [1:0]                 cnt;
    logic [bgsd_pkg::SEG_W-1:0] fa;
    logic [bgsd_pkg::SEG_W-1:0] la;
    logic [bgsd_pkg::SEG_W-1:0] fb;
    logic [bgsd_pkg::SEG_W-1:0] lb;
  } diff_t;

  longint zero_q, start_q, span_q, count_q;
  diff_t  diff_q[$];

  function automatic longint fdiv(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint seg_of(longint x, longint n);
    return fdiv((x - start_q) * n, span_q);
  endfunction

  // lit range from zero to the needle, less the zero-marker segment at either end
  function automatic bit lit_range(longint v, longint n, longint z,
                                   output longint pa, output longint pb);
    longint lo, hi, f, l;
    pa = 0;
    pb = 0;
    lo = (zero_q < v) ? zero_q : v;
    hi = (zero_q < v) ? v : zero_q;
    if (2 * (hi - lo) * n < span_q) return 0;
    f = seg_of(lo, n);
    l = seg_of(hi, n);
    if (f < 0) f = 0;
    if (l > n - 1) l = n - 1;
    if (l < f) return 0;
    if (z == f || z == l) begin
      if (f == l) return 0;
      if (z == f) f++;
      else l--;
    end
    pa = f;
    pb = l;
    return 1;
  endfunction

  function automatic diff_t changed_segments(longint ov, longint nv);
    diff_t  r;
    longint n, z, oa, ob, na, nb, tf, tl;
    longint cf[4], cl[4], rf[2], rl[2];
    bit     op, np;
    int     k, c, j;
    n = (count_q > bgsd_pkg::MAX_SEGMENTS_DEF) ? bgsd_pkg::MAX_SEGMENTS_DEF : count_q;
    k = 0;
    c = 0;
    rf = '{0, 0};
    rl = '{0, 0};
    if (n > 0 && span_q > 0) begin
      z = seg_of(zero_q, n);
      if (z < 0) z = 0;
      if (z > n - 1) z = n - 1;
      op = lit_range(ov, n, z, oa, ob);
      np = lit_range(nv, n, z, na, nb);
      for (int s = 0; s < 2; s++) begin
        longint a, b, p, q;
        bit mine, other;
        mine  = s ? np : op;
        other = s ? op : np;
        a = s ? na : oa;
        b = s ? nb : ob;
        p = s ? oa : na;
        q = s ? ob : nb;
        if (mine) begin
          if (!other || b < p || a > q) begin
            cf[k] = a; cl[k] = b; k++;
          end else begin
            if (a <= p - 1) begin cf[k] = a; cl[k] = p - 1; k++; end
            if (q + 1 <= b) begin cf[k] = q + 1; cl[k] = b; k++; end
          end
        end
      end
      for (int i = 1; i < k; i++) begin
        tf = cf[i];
        tl = cl[i];
        j = i;
        while (j > 0 && cf[j-1] > tf) begin
          cf[j] = cf[j-1];
          cl[j] = cl[j-1];
          j--;
        end
        cf[j] = tf;
        cl[j] = tl;
      end
      for (int i = 0; i < k; i++) begin
        if (c == 0) begin
          rf[0] = cf[i]; rl[0] = cl[i]; c = 1;
        end else if (cf[i] <= rl[c-1] + 1) begin
          if (cl[i] > rl[c-1]) rl[c-1] = cl[i];
        end else if (c < 2) begin
          rf[1] = cf[i]; rl[1] = cl[i]; c = 2;
        end else if (cl[i] > rl[1]) begin
          rl[1] = cl[i];
        end
      end
    end
    r.cnt = c[1:0];
    r.fa = rf[0][bgsd_pkg::SEG_W-1:0];
    r.la = rl[0][bgsd_pkg::SEG_W-1:0];
    r.fb = rf[1][bgsd_pkg::SEG_W-1:0];
    r.lb = rl[1][bgsd_pkg::SEG_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    diff_t got, want;
    if (rst) begin
      zero_q  <= bgsd_pkg::ZERO_ANGLE_RST;
      start_q <= bgsd_pkg::START_ANGLE_RST;
      span_q  <= bgsd_pkg::SWEEP_SPAN_RST;
      count_q <= bgsd_pkg::SEGMENT_COUNT_RST;
      errors  <= 0;
      diff_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          bgsd_pkg::REG_ZERO_ANGLE:    zero_q  <= longint'($signed(pwdata[15:0]));
          bgsd_pkg::REG_START_ANGLE:   start_q <= longint'($signed(pwdata[15:0]));
          bgsd_pkg::REG_SWEEP_SPAN:    span_q  <= longint'(pwdata[14:0]);
          bgsd_pkg::REG_SEGMENT_COUNT: count_q <= longint'(pwdata[6:0]);
          default: ;
        endcase
      end
      if (done) begin
        got = '{range_count, first_a, last_a, first_b, last_b};
        if (diff_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = diff_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected cnt=%0d a=%0d..%0d b=%0d..%0d",
                     $time, want.cnt, want.fa, want.la, want.fb, want.lb);
            $display("%0t:          actual   cnt=%0d a=%0d..%0d b=%0d..%0d",
                     $time, got.cnt, got.fa, got.la, got.fb, got.lb);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy)
        diff_q.push_back(changed_segments(old_angle, new_angle));
      pending <= diff_q.size();
    end
  end
endmodule

>>> tb/tb_bar_gauge_segment_diff.sv
`timescale 1ns / 100ps

module tb_bar_gauge_segment_diff;

  localparam int LATENCY = 11;
  localparam int LIMIT   = 400000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, pready;
  logic signed [bgsd_pkg::ANGLE_W-1:0] old_angle = '0, new_angle = '0;
  logic [1:0] range_count;
  logic [bgsd_pkg::SEG_W-1:0] first_a, last_a, first_b, last_b;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int errors, pending, gap_pct;
  int zr;
  longint cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  bar_gauge_segment_diff u_top (.*);

  bgsd_checker u_chk (.*);

  // setup and access phases, then the bus returns to idle
  task automatic reg_write(bgsd_pkg::reg_addr_t r, logic [31:0] v);
    psel    <= 1;
    pwrite  <= 1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic setup(int z, int s, int sp, int n);
    drain();
    reg_write(bgsd_pkg::REG_ZERO_ANGLE, 32'(z));
    reg_write(bgsd_pkg::REG_START_ANGLE, 32'(s));
    reg_write(bgsd_pkg::REG_SWEEP_SPAN, 32'(sp));
    reg_write(bgsd_pkg::REG_SEGMENT_COUNT, 32'(n));
  endtask

  // one angle pair transfer, with random idle cycles ahead of it
  task automatic send_pair(logic [15:0] o, logic [15:0] n);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start     <= 1;
    old_angle <= o;
    new_angle <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] near_angle();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1, 2:    return 16'($signed($urandom_range(46080)) - 23040);
      default: return 16'($signed($urandom_range(2000)) - 1000 + zr);
    endcase
  endfunction

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) begin
      send_pair(near_angle(), near_angle());
    end
    start <= 0;
  endtask

  initial begin
    gap_pct = 17;
    zr = 0;
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // defaults after reset, field extremes
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h8000, 16'h7fff);
    send_pair(16'h7fff, 16'h8000);
    send_pair(-16'sd23040, 16'sd23040);
    send_pair(16'd17280, 16'd270);
    send_pair(16'd540, 16'd539);
    send_pair(16'hffff, 16'h5555);
    send_pair(16'haaaa, 16'h0001);
    start <= 0;
    // empty gauge: zero span, zero count
    setup(0, 0, 0, 32);
    send_pair(16'd1000, -16'sd1000);
    start <= 0;
    setup(0, 0, 17280, 0);
    send_pair(16'd1000, 16'd5000);
    start <= 0;
    // count beyond maximum, register bits beyond range
    setup(100, -500, 23040, 127);
    send_pair(16'd23040, -16'sd23040);
    send_pair(16'd3000, 16'd100);
    start <= 0;
    setup(-23040, -23040, 32767, 64);
    send_pair(16'd23040, 16'd0);
    send_pair(-16'sd23040, 16'd100);
    start <= 0;
    setup(32'hffff8000, 32'h7fff, 1, 1);
    send_pair(16'h7fff, 16'h8000);
    start <= 0;
    setup(23040, 23040, 23040, 2);
    send_pair(-16'sd23040, 16'd0);
    send_pair(16'd23040, 16'd11520);
    start <= 0;

    for (int ph = 0; ph < 10; ph++) begin
      gap_pct = (ph < 3) ? 17 : (ph < 6) ? 72 : 0;
      zr = $signed($urandom_range(46080)) - 23040;
      case (ph % 4)
        0: setup(zr, zr - $urandom_range(3000), $urandom_range(1, 23040),
                 $urandom_range(1, 64));
        1: setup(zr, $signed($urandom_range(46080)) - 23040,
                 $urandom_range(1, 400), $urandom_range(2, 64));
        2: setup(zr, $urandom, $urandom, $urandom);
        default: setup(zr, zr - 11520, 23040, 64);
      endcase
      random_phase(128);
    end
    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/bgsd_pkg.sv
rtl/core/bgsd_divider.sv
rtl/core/bgsd_range.sv
rtl/core/bar_gauge_segment_diff.sv
tb/bgsd_checker.sv
tb/tb_bar_gauge_segment_diff.sv
